// ===== sv/rfpr_pkg.sv =====
// Shared types, codes and default sizes of the RGB frame point-op and rotate engine.
package rfpr_pkg;

  // Default sizes for the top-level parameters
  localparam int unsigned MAX_WIDTH_DEF    = 64;
  localparam int unsigned MAX_HEIGHT_DEF   = 64;
  localparam int unsigned CHANNEL_BITS_DEF = 16;

  // Fixed field widths of the channels
  localparam int unsigned CHAN_W     = 16;
  localparam int unsigned DIM_CFG_W  = 7;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned MODE_W     = 2;

  // Reset values of the configuration registers
  localparam logic [DIM_CFG_W-1:0] WIDTH_RST  = 7'd64;
  localparam logic [DIM_CFG_W-1:0] HEIGHT_RST = 7'd64;
  localparam logic [CHAN_W-1:0]    MAXCOL_RST = 16'd255;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_MAX_COLOUR   = 3'd2,
    REG_POINT_MODE   = 3'd3,
    REG_ROTATION     = 3'd4
  } cfg_reg_e;

  // Item operation codes
  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_FETCH = 1'b1
  } op_e;

  // Point operations
  typedef enum logic [MODE_W-1:0] {
    PT_NONE     = 2'd0,
    PT_GRAY     = 2'd1,
    PT_MONO     = 2'd2,
    PT_NEGATIVE = 2'd3
  } point_e;

  // Rotation codes (the unused code behaves as rotate right)
  typedef enum logic [MODE_W-1:0] {
    ROT_NONE  = 2'd0,
    ROT_LEFT  = 2'd1,
    ROT_RIGHT = 2'd2,
    ROT_SPARE = 2'd3
  } rot_e;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_LD_SIZE,
    S_LD_WRITE,
    S_FT_POS,
    S_FT_MUL,
    S_FT_READ,
    S_FT_MEAN,
    S_FT_POINT,
    S_FT_OUT
  } state_e;

  // Datapath step strobes from the controller
  typedef struct packed {
    logic capture;
    logic ld_size;
    logic ld_write;
    logic ft_pos;
    logic ft_mul;
    logic ft_read;
    logic ft_mean;
    logic ft_point;
  } dp_cmd_t;

endpackage

// ===== sv/rfpr_if.sv =====
// Channel interfaces: pixel item input, pixel result output and register write.
interface rfpr_in_if;
  import rfpr_pkg::*;
  logic              valid;
  logic              ready;
  logic              operation;
  logic [CHAN_W-1:0] red_in;
  logic [CHAN_W-1:0] green_in;
  logic [CHAN_W-1:0] blue_in;

  modport source (output valid, output operation, output red_in, output green_in,
                  output blue_in, input ready);
  modport sink   (input valid, input operation, input red_in, input green_in,
                  input blue_in, output ready);
endinterface

interface rfpr_out_if;
  import rfpr_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red_out;
  logic [CHAN_W-1:0] green_out;
  logic [CHAN_W-1:0] blue_out;
  logic              last_pixel;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  output last_pixel, input ready);
  modport sink   (input valid, input red_out, input green_out, input blue_out,
                  input last_pixel, output ready);
endinterface

interface rfpr_cfg_if;
  import rfpr_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/rfpr_ctrl.sv =====
// Controller: sequences the load and fetch steps of one item at a time.
module rfpr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_op_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rfpr_pkg::dp_cmd_t cmd_o
);
  import rfpr_pkg::*;

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and step strobes
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = (op_e'(in_op_i) == OP_FETCH) ? S_FT_POS : S_LD_SIZE;
        end
      end
      S_LD_SIZE: begin
        cmd_o.ld_size = 1'b1;
        state_d = S_LD_WRITE;
      end
      S_LD_WRITE: begin
        cmd_o.ld_write = 1'b1;
        state_d = S_IDLE;
      end
      S_FT_POS: begin
        cmd_o.ft_pos = 1'b1;
        state_d = S_FT_MUL;
      end
      S_FT_MUL: begin
        cmd_o.ft_mul = 1'b1;
        state_d = S_FT_READ;
      end
      S_FT_READ: begin
        cmd_o.ft_read = 1'b1;
        state_d = S_FT_MEAN;
      end
      S_FT_MEAN: begin
        cmd_o.ft_mean = 1'b1;
        state_d = S_FT_POINT;
      end
      S_FT_POINT: begin
        cmd_o.ft_point = 1'b1;
        state_d = S_FT_OUT;
      end
      S_FT_OUT: begin
        // Hold the result beat until it is taken
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/rfpr_dpath.sv =====
// Datapath: registers, frame store, address walk and point operations.
module rfpr_dpath #(
  parameter int unsigned MAX_WIDTH    = rfpr_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT   = rfpr_pkg::MAX_HEIGHT_DEF,
  parameter int unsigned CHANNEL_BITS = rfpr_pkg::CHANNEL_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  rfpr_pkg::dp_cmd_t               cmd_i,
  input  logic [rfpr_pkg::CHAN_W-1:0]     red_i,
  input  logic [rfpr_pkg::CHAN_W-1:0]     green_i,
  input  logic [rfpr_pkg::CHAN_W-1:0]     blue_i,
  input  logic                            cfg_valid_i,
  input  logic [rfpr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rfpr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic [rfpr_pkg::CHAN_W-1:0]     red_o,
  output logic [rfpr_pkg::CHAN_W-1:0]     green_o,
  output logic [rfpr_pkg::CHAN_W-1:0]     blue_o,
  output logic                            last_o
);
  import rfpr_pkg::*;

  localparam int unsigned MaxDim = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int unsigned PosW   = $clog2(MaxDim + 1);
  localparam int unsigned CmpW   = (PosW > DIM_CFG_W) ? PosW : DIM_CFG_W;
  localparam int unsigned Depth  = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned ProdW  = 2 * PosW;
  localparam int unsigned CB     = CHANNEL_BITS;
  localparam int unsigned PixW   = 3 * CB;
  localparam int unsigned SumW   = CB + 2;
  // Divide by three as multiply by a rounded-up reciprocal, exact below 2**SumW
  localparam int unsigned Shift  = SumW + 1;
  localparam int unsigned Recip  = ((1 << Shift) + 2) / 3;
  localparam int unsigned MulW   = SumW + Shift;

  // Configuration registers
  logic [DIM_CFG_W-1:0] width_q, height_q;
  logic [CHAN_W-1:0]    maxcol_q;
  point_e               mode_q;
  rot_e                 rot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      maxcol_q <= MAXCOL_RST;
      mode_q   <= PT_NONE;
      rot_q    <= ROT_NONE;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_IMAGE_WIDTH:  width_q  <= cfg_data_i[DIM_CFG_W-1:0];
        REG_IMAGE_HEIGHT: height_q <= cfg_data_i[DIM_CFG_W-1:0];
        REG_MAX_COLOUR:   maxcol_q <= cfg_data_i;
        REG_POINT_MODE:   mode_q   <= point_e'(cfg_data_i[MODE_W-1:0]);
        REG_ROTATION:     rot_q    <= rot_e'(cfg_data_i[MODE_W-1:0]);
        default: ;
      endcase
    end
  end

  // Clamp the image size to 1..maximum
  logic [PosW-1:0] w, h;

  always_comb begin
    if (width_q == '0) begin
      w = PosW'(1);
    end else if (CmpW'(width_q) > CmpW'(MAX_WIDTH)) begin
      w = PosW'(MAX_WIDTH);
    end else begin
      w = PosW'(width_q);
    end
    if (height_q == '0) begin
      h = PosW'(1);
    end else if (CmpW'(height_q) > CmpW'(MAX_HEIGHT)) begin
      h = PosW'(MAX_HEIGHT);
    end else begin
      h = PosW'(height_q);
    end
  end

  // Capture the item beat
  logic [CB-1:0] in_r_q, in_g_q, in_b_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      in_r_q <= red_i[CB-1:0];
      in_g_q <= green_i[CB-1:0];
      in_b_q <= blue_i[CB-1:0];
    end
  end

  // Load path: frame size, then write and advance the load counter
  logic [ProdW-1:0] frame_q;
  logic [ProdW-1:0] load_cnt_q, load_cnt_d;
  logic [ProdW-1:0] ld_idx, ld_nxt;
  logic             ld_we;

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_size) begin
      frame_q <= w * h;
    end
  end

  always_comb begin
    ld_idx     = (load_cnt_q >= frame_q) ? '0 : load_cnt_q;
    ld_nxt     = ld_idx + ProdW'(1);
    load_cnt_d = (ld_nxt >= frame_q) ? '0 : ld_nxt;
    ld_we      = cmd_i.ld_write;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_cnt_q <= '0;
    end else if (ld_we) begin
      load_cnt_q <= load_cnt_d;
    end
  end

  // Fetch position walk in output order
  logic [PosW-1:0] row_q, row_d, col_q, col_d;
  logic [PosW-1:0] ow, oh, cur_row, cur_col, sr, sc, nxt_col, nxt_row;
  logic [PosW-1:0] sr_q, sc_q;
  logic            last_d, last_q;

  always_comb begin
    ow = (rot_q == ROT_NONE) ? w : h;
    oh = (rot_q == ROT_NONE) ? h : w;
    if (row_q >= oh || col_q >= ow) begin
      cur_row = '0;
      cur_col = '0;
    end else begin
      cur_row = row_q;
      cur_col = col_q;
    end
    case (rot_q)
      ROT_NONE: begin
        sr = cur_row;
        sc = cur_col;
      end
      ROT_LEFT: begin
        sr = cur_col;
        sc = w - PosW'(1) - cur_row;
      end
      default: begin
        sr = h - PosW'(1) - cur_col;
        sc = cur_row;
      end
    endcase
    nxt_col = cur_col + PosW'(1);
    nxt_row = cur_row + PosW'(1);
    last_d  = 1'b0;
    row_d   = cur_row;
    col_d   = nxt_col;
    if (nxt_col >= ow) begin
      col_d = '0;
      row_d = nxt_row;
      if (nxt_row >= oh) begin
        row_d  = '0;
        last_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (cmd_i.ft_pos) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ft_pos) begin
      sr_q   <= sr;
      sc_q   <= sc;
      last_q <= last_d;
    end
  end

  // Source address: row times width, then add the column
  logic [ProdW-1:0] prod_q;
  logic [ProdW-1:0] rd_addr;

  always_ff @(posedge clk_i) begin
    if (cmd_i.ft_mul) begin
      prod_q <= sr_q * w;
    end
  end

  assign rd_addr = prod_q + ProdW'(sc_q);

  // Frame store, one write and one registered read port
  logic [PixW-1:0] store_mem [Depth];
  logic [PixW-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (ld_we) begin
      store_mem[ld_idx[AddrW-1:0]] <= {in_r_q, in_g_q, in_b_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ft_read) begin
      rd_q <= store_mem[rd_addr[AddrW-1:0]];
    end
  end

  // Channel mean
  logic [CB-1:0]   px_r, px_g, px_b;
  logic [SumW-1:0] sum;
  logic [MulW-1:0] mean_prod;
  logic [CB-1:0]   mean_q;

  assign px_r      = rd_q[PixW-1 -: CB];
  assign px_g      = rd_q[2*CB-1 -: CB];
  assign px_b      = rd_q[CB-1:0];
  assign sum       = SumW'(px_r) + SumW'(px_g) + SumW'(px_b);
  assign mean_prod = MulW'(sum) * MulW'(Recip);

  always_ff @(posedge clk_i) begin
    if (cmd_i.ft_mean) begin
      mean_q <= mean_prod[Shift +: CB];
    end
  end

  // Point operation into the output registers
  function automatic logic [CHAN_W-1:0] neg_chan(input logic [CHAN_W-1:0] c,
                                                 input logic [CHAN_W-1:0] mx);
    logic [CHAN_W-1:0] res;
    res = (c >= mx) ? '0 : (mx - c);
    return res;
  endfunction

  logic [CHAN_W-1:0] mean_ext, mono, out_r_d, out_g_d, out_b_d;
  logic [CHAN_W-1:0] out_r_q, out_g_q, out_b_q;
  logic              out_last_q;

  always_comb begin
    mean_ext = CHAN_W'(mean_q);
    mono     = (mean_ext > (maxcol_q >> 1)) ? maxcol_q : '0;
    case (mode_q)
      PT_GRAY: begin
        out_r_d = mean_ext;
        out_g_d = mean_ext;
        out_b_d = mean_ext;
      end
      PT_MONO: begin
        out_r_d = mono;
        out_g_d = mono;
        out_b_d = mono;
      end
      PT_NEGATIVE: begin
        out_r_d = neg_chan(CHAN_W'(px_r), maxcol_q);
        out_g_d = neg_chan(CHAN_W'(px_g), maxcol_q);
        out_b_d = neg_chan(CHAN_W'(px_b), maxcol_q);
      end
      default: begin
        out_r_d = CHAN_W'(px_r);
        out_g_d = CHAN_W'(px_g);
        out_b_d = CHAN_W'(px_b);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ft_point) begin
      out_r_q    <= out_r_d;
      out_g_q    <= out_g_d;
      out_b_q    <= out_b_d;
      out_last_q <= last_q;
    end
  end

  assign red_o   = out_r_q;
  assign green_o = out_g_q;
  assign blue_o  = out_b_q;
  assign last_o  = out_last_q;

endmodule

// ===== sv/rgb_frame_point_op_and_rotate.sv =====
// Top level of the RGB frame buffer with point operation and quarter-turn rotation.
//
//   Channel  Dir  Carries
//   pix_i    in   operation, red_in, green_in, blue_in (load or fetch beat)
//   res_o    out  red_out, green_out, blue_out, last_pixel (one beat per fetch)
//   cfg_i    in   index, data (register write, always ready)
//
// One item at a time. A load runs the frame-size multiply, then the store
// write, before the next item is accepted. A fetch runs the position walk,
// row-times-width multiply, store read, mean multiply, point operation and
// result beat, and can stall on the output. The output register holds the beat
// until res_o.ready. Reset clears the load counter, the fetch position and
// the configuration registers; the frame store is not cleared.
module rgb_frame_point_op_and_rotate #(
  parameter int unsigned MAX_WIDTH    = rfpr_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT   = rfpr_pkg::MAX_HEIGHT_DEF,
  parameter int unsigned CHANNEL_BITS = rfpr_pkg::CHANNEL_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rfpr_in_if.sink    pix_i,
  rfpr_out_if.source res_o,
  rfpr_cfg_if.sink   cfg_i
);
  import rfpr_pkg::*;

  dp_cmd_t cmd;

  // Register writes never stall
  assign cfg_i.ready = 1'b1;

  rfpr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pix_i.valid),
    .in_op_i     (pix_i.operation),
    .in_ready_o  (pix_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .cmd_o       (cmd)
  );

  rfpr_dpath #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_HEIGHT   (MAX_HEIGHT),
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .red_i       (pix_i.red_in),
    .green_i     (pix_i.green_in),
    .blue_i      (pix_i.blue_in),
    .cfg_valid_i (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .red_o       (res_o.red_out),
    .green_o     (res_o.green_out),
    .blue_o      (res_o.blue_out),
    .last_o      (res_o.last_pixel)
  );

endmodule
